// ----- rtl/core/xfp_pkg.sv -----
`default_nettype none

package xfp_pkg;

  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 6;
  localparam int INDEX_W = 5;

  // APB register map: one 32-bit word per register
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;
  localparam int REG_BIT = 2;

  localparam logic REG_START_MARKER = 1'b0;
  localparam logic REG_MAX_PAYLOAD  = 1'b1;

  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hAA;
  localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST  = 6'd32;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_ID,
    PH_LEN,
    PH_DATA,
    PH_CSUM
  } phase_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SINGLE,
    BK_READ,
    BK_DATA
  } back_e;

  // one finished frame, handed from parser to emitter
  typedef struct packed {
    logic [BYTE_W-1:0] id;
    logic [LEN_W-1:0]  len;
    logic              err;
    logic              bank;
  } job_t;

  // payload bank handed back by the emitter
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

`default_nettype wire

// ----- rtl/core/xfp_in_if.sv -----
`default_nettype none

interface xfp_in_if;
  logic                       valid;
  logic                       ready;
  logic [xfp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/xfp_out_if.sv -----
`default_nettype none

interface xfp_out_if;
  logic                        valid;
  logic                        ready;
  logic [xfp_pkg::BYTE_W-1:0]  frame_id;
  logic [xfp_pkg::LEN_W-1:0]   frame_len;
  logic                        status;
  logic                        has_data;
  logic [xfp_pkg::BYTE_W-1:0]  data_byte;
  logic [xfp_pkg::INDEX_W-1:0] data_index;
  logic                        last;

  modport source (output valid, output frame_id, output frame_len, output status,
                  output has_data, output data_byte, output data_index, output last,
                  input ready);
  modport sink   (input valid, input frame_id, input frame_len, input status,
                  input has_data, input data_byte, input data_index, input last,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/xfp_ram.sv -----
`default_nettype none

module xfp_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/xfp_front.sv -----
`default_nettype none

module xfp_front #(
  parameter int IW = 5
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  output logic                               ready_o,
  input  wire logic [xfp_pkg::BYTE_W-1:0]    rx_byte_i,
  input  wire logic [xfp_pkg::BYTE_W-1:0]    start_marker_i,
  input  wire logic [xfp_pkg::LEN_W-1:0]     limit_i,
  output logic                               ram_we_o,
  output logic      [IW:0]                   ram_waddr_o,
  output logic      [xfp_pkg::BYTE_W-1:0]    ram_wdata_o,
  output logic                               push_o,
  output xfp_pkg::job_t                      job_o,
  input  wire logic                          q_full_i,
  input  wire xfp_pkg::release_t             rel_i
);

  xfp_pkg::phase_e                phase_q, phase_d;
  logic [xfp_pkg::BYTE_W-1:0]     id_q, id_d;
  logic [xfp_pkg::LEN_W-1:0]      len_q, len_d;
  logic [xfp_pkg::LEN_W-1:0]      fill_q, fill_d;
  logic [xfp_pkg::BYTE_W-1:0]     xor_q, xor_d;
  logic                           bank_q, bank_d;
  logic [1:0]                     busy_q, busy_d;
  logic [xfp_pkg::LEN_W-1:0]      fill_inc;
  logic                           fire;
  logic                           has_payload;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= xfp_pkg::PH_HUNT;
      id_q    <= '0;
      len_q   <= '0;
      fill_q  <= '0;
      xor_q   <= '0;
      bank_q  <= 1'b0;
      busy_q  <= '0;
    end else begin
      phase_q <= phase_d;
      id_q    <= id_d;
      len_q   <= len_d;
      fill_q  <= fill_d;
      xor_q   <= xor_d;
      bank_q  <= bank_d;
      busy_q  <= busy_d;
    end
  end

  assign fill_inc    = fill_q + 6'd1;
  assign ram_waddr_o = {bank_q, fill_q[IW-1:0]};
  assign ram_wdata_o = rx_byte_i;
  assign has_payload = (rx_byte_i == xor_q) && (len_q != '0);

  always_comb begin
    phase_d = phase_q;
    id_d    = id_q;
    len_d   = len_q;
    fill_d  = fill_q;
    xor_d   = xor_q;
    bank_d  = bank_q;
    busy_d  = busy_q;
    ram_we_o = 1'b0;
    push_o   = 1'b0;
    job_o    = '{id: id_q, len: len_q, err: (rx_byte_i != xor_q), bank: bank_q};

    // stall payload bytes while this bank is still being read out, checksum bytes while the job queue is full
    unique case (phase_q)
      xfp_pkg::PH_DATA: ready_o = !busy_q[bank_q];
      xfp_pkg::PH_CSUM: ready_o = !q_full_i;
      default:          ready_o = 1'b1;
    endcase
    fire = valid_i && ready_o;

    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end

    if (fire) begin
      unique case (phase_q)
        xfp_pkg::PH_HUNT: begin
          if (rx_byte_i == start_marker_i) begin
            xor_d   = rx_byte_i;
            phase_d = xfp_pkg::PH_ID;
          end
        end
        xfp_pkg::PH_ID: begin
          id_d    = rx_byte_i;
          xor_d   = xor_q ^ rx_byte_i;
          phase_d = xfp_pkg::PH_LEN;
        end
        xfp_pkg::PH_LEN: begin
          if (rx_byte_i > {2'b00, limit_i}) begin
            // oversize: drop silently, byte is not re-examined as a start
            phase_d = xfp_pkg::PH_HUNT;
            len_d   = '0;
            fill_d  = '0;
            xor_d   = '0;
          end else begin
            len_d   = rx_byte_i[xfp_pkg::LEN_W-1:0];
            xor_d   = xor_q ^ rx_byte_i;
            fill_d  = '0;
            phase_d = (rx_byte_i == '0) ? xfp_pkg::PH_CSUM : xfp_pkg::PH_DATA;
          end
        end
        xfp_pkg::PH_DATA: begin
          ram_we_o = 1'b1;
          xor_d    = xor_q ^ rx_byte_i;
          fill_d   = fill_inc;
          if (fill_inc >= len_q) begin
            phase_d = xfp_pkg::PH_CSUM;
          end
        end
        xfp_pkg::PH_CSUM: begin
          push_o = 1'b1;
          if (has_payload) begin
            busy_d[bank_q] = 1'b1;
            bank_d         = !bank_q;
          end
          phase_d = xfp_pkg::PH_HUNT;
          len_d   = '0;
          fill_d  = '0;
          xor_d   = '0;
        end
        default: begin
          phase_d = xfp_pkg::PH_HUNT;
          len_d   = '0;
          fill_d  = '0;
          xor_d   = '0;
        end
      endcase
    end
  end

  a_write_free_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> !busy_q[bank_q])
    else $error("payload written into a bank still being emitted");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_full_i)
    else $error("frame pushed into a full queue");

endmodule

`default_nettype wire

// ----- rtl/core/xfp_queue.sv -----
`default_nettype none

module xfp_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire xfp_pkg::job_t wdata_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output xfp_pkg::job_t      rdata_o,
  output logic               empty_o
);

  xfp_pkg::job_t mem_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i |-> !full_o) and (pop_i |-> !empty_o))
    else $error("job queue overflow or underflow");

endmodule

`default_nettype wire

// ----- rtl/core/xfp_back.sv -----
`default_nettype none

module xfp_back #(
  parameter int IW = 5
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_empty_i,
  input  wire xfp_pkg::job_t                 q_head_i,
  output logic                               pop_o,
  output logic                               ram_re_o,
  output logic      [IW:0]                   ram_raddr_o,
  input  wire logic [xfp_pkg::BYTE_W-1:0]    ram_rdata_i,
  output xfp_pkg::release_t                  rel_o,
  output logic                               valid_o,
  input  wire logic                          ready_i,
  output logic      [xfp_pkg::BYTE_W-1:0]    frame_id_o,
  output logic      [xfp_pkg::LEN_W-1:0]     frame_len_o,
  output logic                               status_o,
  output logic                               has_data_o,
  output logic      [xfp_pkg::BYTE_W-1:0]    data_byte_o,
  output logic      [xfp_pkg::INDEX_W-1:0]   data_index_o,
  output logic                               last_o
);

  xfp_pkg::back_e              state_q, state_d;
  xfp_pkg::job_t               job_q, job_d;
  logic [xfp_pkg::LEN_W-1:0]   idx_q, idx_d;
  logic [xfp_pkg::LEN_W-1:0]   idx_inc;
  logic                        out_valid_q, out_valid_d;
  logic                        out_free;
  logic                        load;
  logic                        ld_status, ld_has, ld_last;
  logic [xfp_pkg::BYTE_W-1:0]  ld_data;
  logic [xfp_pkg::INDEX_W-1:0] ld_index;
  logic [xfp_pkg::BYTE_W-1:0]  id_q;
  logic [xfp_pkg::LEN_W-1:0]   len_q;
  logic                        status_q, has_q, last_q;
  logic [xfp_pkg::BYTE_W-1:0]  data_q;
  logic [xfp_pkg::INDEX_W-1:0] index_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= xfp_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    idx_q <= idx_d;
    if (load) begin
      id_q     <= job_q.id;
      len_q    <= job_q.len;
      status_q <= ld_status;
      has_q    <= ld_has;
      data_q   <= ld_data;
      index_q  <= ld_index;
      last_q   <= ld_last;
    end
  end

  assign out_free    = !out_valid_q || ready_i;
  assign idx_inc     = idx_q + 6'd1;
  assign ram_raddr_o = {job_q.bank, idx_q[IW-1:0]};

  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    idx_d     = idx_q;
    pop_o     = 1'b0;
    ram_re_o  = 1'b0;
    rel_o     = '{valid: 1'b0, bank: job_q.bank};
    load      = 1'b0;
    ld_status = 1'b0;
    ld_has    = 1'b0;
    ld_data   = '0;
    ld_index  = '0;
    ld_last   = 1'b1;

    unique case (state_q)
      xfp_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          job_d   = q_head_i;
          idx_d   = '0;
          state_d = (q_head_i.err || q_head_i.len == '0) ? xfp_pkg::BK_SINGLE
                                                         : xfp_pkg::BK_READ;
        end
      end
      xfp_pkg::BK_SINGLE: begin
        if (out_free) begin
          load      = 1'b1;
          ld_status = job_q.err;
          state_d   = xfp_pkg::BK_IDLE;
        end
      end
      xfp_pkg::BK_READ: begin
        ram_re_o = 1'b1;
        state_d  = xfp_pkg::BK_DATA;
      end
      xfp_pkg::BK_DATA: begin
        if (out_free) begin
          load     = 1'b1;
          ld_has   = 1'b1;
          ld_data  = ram_rdata_i;
          ld_index = idx_q[xfp_pkg::INDEX_W-1:0];
          ld_last  = (idx_inc == job_q.len);
          if (ld_last) begin
            rel_o.valid = 1'b1;
            state_d     = xfp_pkg::BK_IDLE;
          end else begin
            idx_d   = idx_inc;
            state_d = xfp_pkg::BK_READ;
          end
        end
      end
      default: state_d = xfp_pkg::BK_IDLE;
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end else if (ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign valid_o      = out_valid_q;
  assign frame_id_o   = id_q;
  assign frame_len_o  = len_q;
  assign status_o     = status_q;
  assign has_data_o   = has_q;
  assign data_byte_o  = data_q;
  assign data_index_o = index_q;
  assign last_o       = last_q;

  a_release_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_o.valid |=> (out_valid_q && last_q && has_q))
    else $error("bank released without a final payload transfer pending");

  a_payload_job_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re_o |-> (!job_q.err && job_q.len != '0 && idx_q < job_q.len))
    else $error("payload read for a frame without payload");

endmodule

`default_nettype wire

// ----- rtl/core/xor_frame_parser_unit.sv -----
`default_nettype none

// Input: one byte per cycle; a payload byte stalls while both payload banks await read-out,
//   a checksum byte while the two-entry job queue is full.
// Out: each payload result takes a RAM read, then an output register load that waits for a free output register.
// Reset (async, rst_ni low): parser hunts, queue and output empty, registers 0xAA and 32.
// Payload RAM has no reset and no clearing pass; only bytes of the current frame are read.
module xor_frame_parser_unit #(
  parameter int PAYLOAD_DEPTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  xfp_in_if.sink                            rx_if,
  xfp_out_if.source                         res_if,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [xfp_pkg::APB_AW-1:0]   paddr,
  input  wire logic [xfp_pkg::APB_DW-1:0]   pwdata,
  output logic      [xfp_pkg::APB_DW-1:0]   prdata,
  output logic                              pready
);

  localparam int IW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int RAM_DEPTH = 2 ** (IW + 1);
  localparam logic [xfp_pkg::LEN_W-1:0] DEPTH_LIMIT = xfp_pkg::LEN_W'(PAYLOAD_DEPTH);

  logic [xfp_pkg::BYTE_W-1:0] start_q;
  logic [xfp_pkg::LEN_W-1:0]  maxp_q;
  logic [xfp_pkg::LEN_W-1:0]  limit;
  logic                       cfg_wr;

  logic                       ram_we, ram_re;
  logic [IW:0]                ram_waddr, ram_raddr;
  logic [xfp_pkg::BYTE_W-1:0] ram_wdata, ram_rdata;
  logic                       push, pop, q_full, q_empty;
  xfp_pkg::job_t              push_job, head_job;
  xfp_pkg::release_t          rel;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= xfp_pkg::START_MARKER_RST;
      maxp_q  <= xfp_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_wr) begin
      unique case (paddr[xfp_pkg::REG_BIT])
        xfp_pkg::REG_START_MARKER: start_q <= pwdata[xfp_pkg::BYTE_W-1:0];
        xfp_pkg::REG_MAX_PAYLOAD:  maxp_q  <= pwdata[xfp_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[xfp_pkg::REG_BIT])
      xfp_pkg::REG_START_MARKER: prdata = {{(xfp_pkg::APB_DW - xfp_pkg::BYTE_W){1'b0}}, start_q};
      xfp_pkg::REG_MAX_PAYLOAD:  prdata = {{(xfp_pkg::APB_DW - xfp_pkg::LEN_W){1'b0}}, maxp_q};
      default:                   prdata = '0;
    endcase
  end

  assign limit = (maxp_q > DEPTH_LIMIT) ? DEPTH_LIMIT : maxp_q;

  xfp_front #(.IW(IW)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (rx_if.valid),
    .ready_o        (rx_if.ready),
    .rx_byte_i      (rx_if.rx_byte),
    .start_marker_i (start_q),
    .limit_i        (limit),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .push_o         (push),
    .job_o          (push_job),
    .q_full_i       (q_full),
    .rel_i          (rel)
  );

  xfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .rdata_o (head_job),
    .empty_o (q_empty)
  );

  xfp_ram #(.WIDTH(xfp_pkg::BYTE_W), .DEPTH(RAM_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  xfp_back #(.IW(IW)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_head_i     (head_job),
    .pop_o        (pop),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .rel_o        (rel),
    .valid_o      (res_if.valid),
    .ready_i      (res_if.ready),
    .frame_id_o   (res_if.frame_id),
    .frame_len_o  (res_if.frame_len),
    .status_o     (res_if.status),
    .has_data_o   (res_if.has_data),
    .data_byte_o  (res_if.data_byte),
    .data_index_o (res_if.data_index),
    .last_o       (res_if.last)
  );

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int PAYLOAD_DEPTH = 32;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int DRAIN_CYCLES  = 12;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 46;

  typedef struct packed {
    logic [xfp_pkg::BYTE_W-1:0]  frame_id;
    logic [xfp_pkg::LEN_W-1:0]   frame_len;
    logic                        status;
    logic                        has_data;
    logic [xfp_pkg::BYTE_W-1:0]  data_byte;
    logic [xfp_pkg::INDEX_W-1:0] data_index;
    logic                        last;
  } frame_result_t;

  typedef struct {
    logic [xfp_pkg::BYTE_W-1:0] rx;
    bit                         typed;
    frame_result_t              res;
  } stim_row_t;

  localparam frame_result_t NO_RESULT = '0;

  logic clk_i = 1'b0;
  logic rst_ni;

  xfp_in_if  rx_if ();
  xfp_out_if res_if ();

  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [xfp_pkg::APB_AW-1:0]   paddr;
  logic [xfp_pkg::APB_DW-1:0]   pwdata;
  logic [xfp_pkg::APB_DW-1:0]   prdata;
  logic                         pready;

  xor_frame_parser_unit #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_if  (rx_if),
    .res_if (res_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk_i = ~clk_i;

  // parser model state and register copies
  xfp_pkg::phase_e            ph;
  logic [xfp_pkg::BYTE_W-1:0] cur_id;
  logic [xfp_pkg::LEN_W-1:0]  cur_len;
  logic [xfp_pkg::LEN_W-1:0]  fill;
  logic [xfp_pkg::BYTE_W-1:0] run_xor;
  logic [xfp_pkg::BYTE_W-1:0] payload_mem [PAYLOAD_DEPTH];
  logic [xfp_pkg::BYTE_W-1:0] cfg_marker;
  logic [xfp_pkg::LEN_W-1:0]  cfg_max;

  frame_result_t frame_results_due [$];
  frame_result_t parsed_now [$];
  frame_result_t got, want;

  int  fail_count;
  int  sent_items;
  bit  no_gaps;
  bit  hold_req;

  // directed bytes: zero-length frame, checksum error, over-long lengths,
  // a one-byte payload and an error on a frame with payload
  stim_row_t reset_rows [25] = '{
    '{8'hAA, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'hAA, 1'b1, '{8'h00, 6'd0, 1'b0, 1'b0, 8'h00, 5'd0, 1'b1}},
    '{8'hAA, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, '{8'hFF, 6'd0, 1'b1, 1'b0, 8'h00, 5'd0, 1'b1}},
    '{8'hAA, 1'b0, NO_RESULT},
    '{8'h12, 1'b0, NO_RESULT},
    '{8'h21, 1'b0, NO_RESULT},
    '{8'hAA, 1'b0, NO_RESULT},
    '{8'h12, 1'b0, NO_RESULT},
    '{8'hAA, 1'b0, NO_RESULT},  // dropped length, must not reopen a frame
    '{8'hAA, 1'b0, NO_RESULT},
    '{8'h34, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'h60, 1'b0, NO_RESULT},
    '{8'hAA, 1'b0, NO_RESULT},
    '{8'h56, 1'b0, NO_RESULT},
    '{8'h02, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, '{8'h56, 6'd2, 1'b1, 1'b0, 8'h00, 5'd0, 1'b1}}
  };

  function automatic void back_to_hunt();
    ph      = xfp_pkg::PH_HUNT;
    cur_len = '0;
    fill    = '0;
    run_xor = '0;
  endfunction

  function automatic frame_result_t make_result(logic st, logic has,
                                                logic [xfp_pkg::BYTE_W-1:0] d,
                                                logic [xfp_pkg::INDEX_W-1:0] idx, logic lst);
    frame_result_t r;
    r.frame_id   = cur_id;
    r.frame_len  = cur_len;
    r.status     = st;
    r.has_data   = has;
    r.data_byte  = d;
    r.data_index = idx;
    r.last       = lst;
    return r;
  endfunction

  // advance the parser model by one byte; results land in parsed_now
  function automatic void parse_rx_byte(logic [xfp_pkg::BYTE_W-1:0] b);
    int lim;
    parsed_now.delete();
    case (ph)
      xfp_pkg::PH_HUNT: begin
        if (b == cfg_marker) begin
          run_xor = b;
          ph      = xfp_pkg::PH_ID;
        end
      end
      xfp_pkg::PH_ID: begin
        cur_id  = b;
        run_xor = run_xor ^ b;
        ph      = xfp_pkg::PH_LEN;
      end
      xfp_pkg::PH_LEN: begin
        lim = (int'(cfg_max) > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : int'(cfg_max);
        if (int'(b) > lim) begin
          back_to_hunt();
        end else begin
          cur_len = b[xfp_pkg::LEN_W-1:0];
          run_xor = run_xor ^ b;
          fill    = '0;
          ph      = (b == 0) ? xfp_pkg::PH_CSUM : xfp_pkg::PH_DATA;
        end
      end
      xfp_pkg::PH_DATA: begin
        if (int'(fill) < PAYLOAD_DEPTH) payload_mem[fill[xfp_pkg::INDEX_W-1:0]] = b;
        run_xor = run_xor ^ b;
        fill    = fill + 1'b1;
        if (fill >= cur_len) ph = xfp_pkg::PH_CSUM;
      end
      xfp_pkg::PH_CSUM: begin
        if (b != run_xor) begin
          parsed_now.push_back(make_result(1'b1, 1'b0, '0, '0, 1'b1));
        end else if (cur_len == 0) begin
          parsed_now.push_back(make_result(1'b0, 1'b0, '0, '0, 1'b1));
        end else begin
          for (int i = 0; i < int'(cur_len) && i < PAYLOAD_DEPTH; i++) begin
            parsed_now.push_back(make_result(1'b0, 1'b1, payload_mem[i],
                                             xfp_pkg::INDEX_W'(i),
                                             (i + 1 == int'(cur_len))));
          end
        end
        back_to_hunt();
      end
      default: back_to_hunt();
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 50);
  endfunction

  // one byte transfer on the receive channel, then prediction
  task automatic send_byte(input logic [xfp_pkg::BYTE_W-1:0] b, input bit counted,
                           input bit typed, input frame_result_t typed_res);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    parse_rx_byte(b);
    if (typed) frame_results_due.push_back(typed_res);
    else foreach (parsed_now[k]) frame_results_due.push_back(parsed_now[k]);
    if (counted) sent_items++;
  endtask

  task automatic send_plain(input logic [xfp_pkg::BYTE_W-1:0] b);
    send_byte(b, 1'b1, 1'b0, NO_RESULT);
  endtask

  task automatic send_noise();
    logic [xfp_pkg::BYTE_W-1:0] b;
    do b = xfp_pkg::BYTE_W'($urandom); while (b == cfg_marker);
    send_byte(b, 1'b0, 1'b0, NO_RESULT);
  endtask

  // a frame under the current marker; over-long lengths stop after the length byte
  task automatic send_frame(input int unsigned len, input bit good_sum,
                            input int unsigned keep);
    logic [xfp_pkg::BYTE_W-1:0] fr [$];
    logic [xfp_pkg::BYTE_W-1:0] csum;
    int lim;
    lim = (int'(cfg_max) > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : int'(cfg_max);
    fr.push_back(cfg_marker);
    fr.push_back(xfp_pkg::BYTE_W'($urandom));
    fr.push_back(xfp_pkg::BYTE_W'(len));
    if (int'(len) <= lim) begin
      repeat (len) fr.push_back(xfp_pkg::BYTE_W'($urandom));
      csum = '0;
      foreach (fr[k]) csum = csum ^ fr[k];
      fr.push_back(good_sum ? csum : csum ^ xfp_pkg::BYTE_W'($urandom_range(1, 255)));
    end
    foreach (fr[k]) if (k < int'(keep)) send_plain(fr[k]);
  endtask

  task automatic wait_drained();
    rx_if.valid <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic idx, input logic [xfp_pkg::APB_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= xfp_pkg::APB_AW'(idx) << xfp_pkg::REG_BIT;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == xfp_pkg::REG_START_MARKER) cfg_marker = val[xfp_pkg::BYTE_W-1:0];
    else cfg_max = val[xfp_pkg::LEN_W-1:0];
    @(posedge clk_i);
  endtask

  function automatic int pick_len(int lim);
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(0, (lim < 4) ? lim : 4);
    if (r < 8) return $urandom_range(0, lim);
    return (r == 8) ? lim : 0;
  endfunction

  task automatic run_random_phase(input logic [xfp_pkg::BYTE_W-1:0] marker,
                                  input logic [xfp_pkg::LEN_W-1:0] mx, input bit pressure);
    int target, lim, kind;
    wait_drained();
    reg_write(xfp_pkg::REG_START_MARKER, xfp_pkg::APB_DW'(marker));
    reg_write(xfp_pkg::REG_MAX_PAYLOAD, xfp_pkg::APB_DW'(mx));
    lim = (int'(cfg_max) > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : int'(cfg_max);
    no_gaps = pressure;
    if (pressure) hold_req = 1'b1;
    target = sent_items + PHASE_ITEMS;
    while (sent_items < target) begin
      if (!pressure) no_gaps = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 62) send_frame(pick_len(lim), 1'b1, 999);
      else if (kind < 75) send_frame(pick_len(lim), 1'b0, 999);
      else if (kind < 83) send_frame($urandom_range(lim + 1, 255), 1'b1, 999);
      else if (kind < 93) repeat ($urandom_range(1, 3)) send_noise();
      else send_frame(pick_len(lim), 1'b1, $urandom_range(1, 4));  // cut short
    end
    no_gaps = 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (res_if.valid && res_if.ready) begin
      got = '{res_if.frame_id, res_if.frame_len, res_if.status, res_if.has_data,
              res_if.data_byte, res_if.data_index, res_if.last};
      if (frame_results_due.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result id=%h len=%0d st=%b has=%b data=%h idx=%0d last=%b",
                 $time, got.frame_id, got.frame_len, got.status, got.has_data,
                 got.data_byte, got.data_index, got.last);
      end else begin
        want = frame_results_due.pop_front();
        if (got.frame_id !== want.frame_id || got.frame_len !== want.frame_len ||
            got.status !== want.status || got.has_data !== want.has_data ||
            got.data_byte !== want.data_byte || got.data_index !== want.data_index ||
            got.last !== want.last) begin
          fail_count++;
          $display("%0t: expected id=%h len=%0d st=%b has=%b data=%h idx=%0d last=%b",
                   $time, want.frame_id, want.frame_len, want.status, want.has_data,
                   want.data_byte, want.data_index, want.last);
          $display("%0t: actual   id=%h len=%0d st=%b has=%b data=%h idx=%0d last=%b",
                   $time, got.frame_id, got.frame_len, got.status, got.has_data,
                   got.data_byte, got.data_index, got.last);
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    int stall_left, calm_left;
    stall_left = 0;
    calm_left  = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end else if (calm_left > 0) begin
        calm_left--;
        res_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        case ($urandom_range(0, 99)) inside
          [0:1]:   calm_left  = $urandom_range(50, 150);
          [2:13]:  stall_left = $urandom_range(1, 3);
          [14:16]: stall_left = $urandom_range(10, 40);
          default: ;
        endcase
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    res_if.ready  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    fail_count    = 0;
    sent_items    = 0;
    no_gaps       = 1'b0;
    hold_req      = 1'b0;
    cfg_marker    = xfp_pkg::START_MARKER_RST;
    cfg_max       = xfp_pkg::MAX_PAYLOAD_RST;
    cur_id        = '0;
    foreach (payload_mem[k]) payload_mem[k] = '0;
    back_to_hunt();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (reset_rows[k]) send_byte(reset_rows[k].rx, 1'b1, reset_rows[k].typed,
                                      reset_rows[k].res);

    // marker changed while a frame is open: checksum keeps the received start
    wait_drained();
    send_plain(cfg_marker);
    wait_drained();
    reg_write(xfp_pkg::REG_START_MARKER, xfp_pkg::APB_DW'(8'h3C));
    send_plain(8'h5A);
    send_plain(8'h00);
    send_plain(8'hAA ^ 8'h5A);
    send_frame(3, 1'b1, 999);

    // limit lowered before the length arrives
    wait_drained();
    send_plain(cfg_marker);
    send_plain(8'h77);
    wait_drained();
    reg_write(xfp_pkg::REG_MAX_PAYLOAD, xfp_pkg::APB_DW'(6'd3));
    send_plain(8'h04);
    send_frame(3, 1'b1, 999);
    send_frame(3, 1'b0, 999);

    // limit lowered after the length: the open frame still completes
    wait_drained();
    send_plain(cfg_marker);
    send_plain(8'hC3);
    send_plain(8'h02);
    wait_drained();
    reg_write(xfp_pkg::REG_MAX_PAYLOAD, xfp_pkg::APB_DW'(6'd0));
    send_plain(8'h81);
    send_plain(8'h7E);
    send_plain(8'h3C ^ 8'hC3 ^ 8'h02 ^ 8'h81 ^ 8'h7E);

    run_random_phase(8'h00, 6'd0, 1'b0);
    run_random_phase(8'hFF, 6'd32, 1'b0);
    run_random_phase(xfp_pkg::BYTE_W'($urandom), xfp_pkg::LEN_W'($urandom_range(1, 31)), 1'b0);
    run_random_phase(8'h55, 6'd32, 1'b1);
    run_random_phase(xfp_pkg::START_MARKER_RST, xfp_pkg::MAX_PAYLOAD_RST, 1'b0);

    wait_drained();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
